// ----- rtl/bpa_pkg.sv -----
// ============================================================================
// bpa_pkg
// Shared constants, types and index helpers for the buddy page allocator.
// ============================================================================
`default_nettype none

package bpa_pkg;

    localparam int LOG2_PAGES     = 10;
    localparam int RESERVED_ORDER = 0;

    localparam int PAGES   = 1 << LOG2_PAGES;
    localparam int LEVELS  = LOG2_PAGES + 1;
    localparam int NODES   = 2 * PAGES;
    localparam int PG_W    = LOG2_PAGES;
    localparam int LNK_W   = LOG2_PAGES + 1;
    localparam int NODE_W  = LOG2_PAGES + 1;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int RES_ORD = (RESERVED_ORDER > LOG2_PAGES) ? LOG2_PAGES : RESERVED_ORDER;
    localparam int RES_LVL = LOG2_PAGES - RES_ORD;

    // Port payload widths.
    localparam int OP_W   = 1;
    localparam int ORD_W  = 4;
    localparam int PIDX_W = 10;
    localparam int STAT_W = 2;
    localparam int FREE_W = 11;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(PAGES);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_ORDER = 2'd1,
        STAT_NO_BLOCK  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SEARCH, S_SPLIT_NODE, S_SPLIT_NEXT, S_ALLOC_END,
        S_MRG_RD, S_MRG_CHK, S_MRG_NEXT, S_FREE_END,
        S_RM_RD, S_RM_WR, S_INS1, S_INS2, S_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [PG_W-1:0]  addr;
        logic [LNK_W-1:0] data;
    } t_lnk_wr;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic              data;
    } t_node_wr;

    function automatic logic [NODE_W-1:0] node_of(logic [PG_W-1:0] p, logic [LVL_W-1:0] l);
        logic [LVL_W-1:0] sh;
        sh = LVL_W'(LOG2_PAGES) - l;
        return ((NODE_W'(1) << l) - NODE_W'(1)) + (NODE_W'(p) >> sh);
    endfunction

    function automatic logic [PG_W-1:0] buddy_of(logic [PG_W-1:0] p, logic [LVL_W-1:0] l);
        logic [LVL_W-1:0] sh;
        sh = LVL_W'(LOG2_PAGES) - l;
        return p ^ (PG_W'(1) << sh);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bpa_if.sv -----
// ============================================================================
// bpa_in_if / bpa_out_if
// Request and response channels of the buddy page allocator.
// ============================================================================
`default_nettype none

interface bpa_in_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ORD_W-1:0]  block_order;
    logic [PIDX_W-1:0] page_index;

    modport source (output valid, operation, block_order, page_index, input ready);
    modport sink   (input valid, operation, block_order, page_index, output ready);
endinterface

interface bpa_out_if import bpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [PIDX_W-1:0] result_page;
    logic [FREE_W-1:0] free_pages;

    modport source (output valid, status, result_page, free_pages, input ready);
    modport sink   (input valid, status, result_page, free_pages, output ready);
endinterface

`default_nettype wire

// ----- rtl/buddy_page_allocator.sv -----
// ============================================================================
// buddy_page_allocator
// Buddy allocator over 2^LOG2_PAGES pages with per-level free lists.
// ============================================================================
// Requests arrive on i_req (operation, block_order, page_index) and each
// request produces exactly one response on o_rsp (status, result_page,
// free_pages); a transfer happens when valid and ready are both high.
// Requests are handled one at a time. An allocate whose own list holds a
// block takes it directly; one that has to split first searches the lists
// of larger blocks and then walks down the levels, splitting at each one.
// A free checks the buddy at each level and merges while the buddy is free.
// The response sits in an output register, so the next request can be
// taken while a response is still waiting; if the receiver stalls, the
// next response waits inside the block and i_req.ready stays low.
// After reset a clearing pass over the 2*2^LOG2_PAGES node addresses
// initializes the node bitmap and link memories; i_req.ready is low
// during that pass.
// ============================================================================
`default_nettype none

module buddy_page_allocator import bpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpa_in_if.sink    i_req,
    bpa_out_if.source o_rsp
);

    t_lnk_wr           nxt_wr, prv_wr;
    t_node_wr          node_wr;
    logic [PG_W-1:0]   lnk_raddr;
    logic [LNK_W-1:0]  nxt_rd, prv_rd;
    logic [NODE_W-1:0] node_raddr;
    logic              node_rd;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_nxt_wr    (nxt_wr),
        .o_prv_wr    (prv_wr),
        .o_lnk_raddr (lnk_raddr),
        .i_nxt_rd    (nxt_rd),
        .i_prv_rd    (prv_rd),
        .o_node_wr   (node_wr),
        .o_node_raddr(node_raddr),
        .i_node_rd   (node_rd)
    );

    bpa_ram #(.WIDTH(LNK_W), .DEPTH(PAGES)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (nxt_wr.we),
        .i_waddr(nxt_wr.addr),
        .i_wdata(nxt_wr.data),
        .i_raddr(lnk_raddr),
        .o_rdata(nxt_rd)
    );

    bpa_ram #(.WIDTH(LNK_W), .DEPTH(PAGES)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (prv_wr.we),
        .i_waddr(prv_wr.addr),
        .i_wdata(prv_wr.data),
        .i_raddr(lnk_raddr),
        .o_rdata(prv_rd)
    );

    bpa_ram #(.WIDTH(1), .DEPTH(NODES)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (node_wr.we),
        .i_waddr(node_wr.addr),
        .i_wdata(node_wr.data),
        .i_raddr(node_raddr),
        .o_rdata(node_rd)
    );

endmodule

`default_nettype wire

// ----- rtl/bpa_ram.sv -----
// ============================================================================
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
// ============================================================================
// bpa_ctrl
// Request sequencer: list heads, free count and the read-modify-write
// steps on the link and node memories, plus the response register.
// ============================================================================
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    bpa_in_if.sink            i_req,
    bpa_out_if.source         o_rsp,
    output t_lnk_wr           o_nxt_wr,
    output t_lnk_wr           o_prv_wr,
    output logic [PG_W-1:0]   o_lnk_raddr,
    input  wire logic [LNK_W-1:0] i_nxt_rd,
    input  wire logic [LNK_W-1:0] i_prv_rd,
    output t_node_wr          o_node_wr,
    output logic [NODE_W-1:0] o_node_raddr,
    input  wire logic         i_node_rd
);

    t_state             r_state, n_state, r_ret, n_ret;
    logic [LNK_W-1:0]   r_head [LEVELS];
    logic [LNK_W-1:0]   n_head [LEVELS];
    logic [LNK_W-1:0]   r_count, n_count;
    logic [NODE_W-1:0]  r_clr, n_clr;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [LVL_W-1:0]   r_l, n_l, r_sl, n_sl;
    logic [PG_W-1:0]    r_p, n_p, r_blk, n_blk, r_page, n_page;
    t_status            r_stat, n_stat;
    logic               r_ov, n_ov;
    logic [STAT_W-1:0]  r_ostat, n_ostat;
    logic [PIDX_W-1:0]  r_opage, n_opage;
    logic [FREE_W-1:0]  r_ofree, n_ofree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_IDLE;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_count <= LNK_W'(PAGES - (1 << RES_ORD));
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= (i >= 1 && i <= RES_LVL) ? LNK_W'(PAGES >> i) : NIL;
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_count <= n_count;
            r_head  <= n_head;
        end
        r_ord   <= n_ord;
        r_l     <= n_l;
        r_sl    <= n_sl;
        r_p     <= n_p;
        r_blk   <= n_blk;
        r_page  <= n_page;
        r_stat  <= n_stat;
        r_ostat <= n_ostat;
        r_opage <= n_opage;
        r_ofree <= n_ofree;
    end

    assign o_lnk_raddr = r_p;
    assign o_node_raddr = node_of(buddy_of(r_blk, r_sl), r_sl);
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.status = r_ostat;
    assign o_rsp.result_page = r_opage;
    assign o_rsp.free_pages = r_ofree;

    always_comb begin
        logic [LNK_W-1:0]   head;
        logic [LNK_W-1:0]   sz;
        logic [LNK_W:0]     sum;
        logic [PG_W-1:0]    p_in;
        logic [PG_W-1:0]    bd;
        logic [LVL_W-1:0]   l_in;
        logic [ORD_W-1:0]   ord_in;

        n_state = r_state;
        n_ret   = r_ret;
        n_head  = r_head;
        n_count = r_count;
        n_clr   = r_clr;
        n_ord   = r_ord;
        n_l     = r_l;
        n_sl    = r_sl;
        n_p     = r_p;
        n_blk   = r_blk;
        n_page  = r_page;
        n_stat  = r_stat;
        n_ov    = r_ov && !o_rsp.ready;
        n_ostat = r_ostat;
        n_opage = r_opage;
        n_ofree = r_ofree;
        o_nxt_wr  = '0;
        o_prv_wr  = '0;
        o_node_wr = '0;

        head   = r_head[r_sl];
        sz     = LNK_W'(1) << r_ord;
        sum    = {1'b0, r_count} + {1'b0, sz};
        ord_in = i_req.block_order;
        l_in   = LVL_W'(LOG2_PAGES) - LVL_W'(ord_in);
        p_in   = PG_W'(i_req.page_index)
                 & ~((PG_W'(1) << ord_in) - PG_W'(1));
        bd     = buddy_of(r_blk, r_sl);

        case (r_state)
            S_INIT: begin
                // Clearing pass over the node bitmap and both link memories.
                o_node_wr.we   = 1'b1;
                o_node_wr.addr = r_clr;
                o_node_wr.data = (r_clr != '0) && ((r_clr & (r_clr + NODE_W'(1))) == '0);
                o_nxt_wr.we    = !r_clr[NODE_W-1];
                o_nxt_wr.addr  = r_clr[PG_W-1:0];
                o_nxt_wr.data  = NIL;
                o_prv_wr       = o_nxt_wr;
                n_clr          = r_clr + NODE_W'(1);
                if (r_clr == NODE_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_ord  = ord_in;
                    n_l    = l_in;
                    n_sl   = l_in;
                    n_page = '0;
                    n_blk  = p_in;
                    if (32'(ord_in) > LOG2_PAGES) begin
                        n_stat  = STAT_BAD_ORDER;
                        n_state = S_DONE;
                    end else if (t_op'(i_req.operation) == OP_ALLOC) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_MRG_RD;
                    end
                end
            end
            S_SEARCH: begin
                if (!head[LNK_W-1]) begin
                    n_blk = head[PG_W-1:0];
                    n_p   = head[PG_W-1:0];
                    if (r_sl == r_l) begin
                        n_state = S_ALLOC_END;
                    end else begin
                        n_ret   = S_SPLIT_NODE;
                        n_state = S_RM_RD;
                    end
                end else if (r_sl == '0) begin
                    n_stat  = STAT_NO_BLOCK;
                    n_state = S_DONE;
                end else begin
                    n_sl = r_sl - LVL_W'(1);
                end
            end
            S_SPLIT_NODE: begin
                if (r_sl == r_l) begin
                    // The final split half goes onto its list and is then taken.
                    n_p     = r_blk;
                    n_ret   = S_ALLOC_END;
                    n_state = S_INS1;
                end else begin
                    o_node_wr.we   = 1'b1;
                    o_node_wr.addr = node_of(r_blk, r_sl);
                    o_node_wr.data = 1'b1;
                    n_state        = S_SPLIT_NEXT;
                end
            end
            S_SPLIT_NEXT: begin
                o_node_wr.we   = 1'b1;
                o_node_wr.addr = node_of(buddy_of(r_blk, r_sl + LVL_W'(1)), r_sl + LVL_W'(1));
                o_node_wr.data = 1'b0;
                n_p     = buddy_of(r_blk, r_sl + LVL_W'(1));
                n_sl    = r_sl + LVL_W'(1);
                n_ret   = S_SPLIT_NODE;
                n_state = S_INS1;
            end
            S_ALLOC_END: begin
                o_node_wr.we   = 1'b1;
                o_node_wr.addr = node_of(r_blk, r_l);
                o_node_wr.data = 1'b1;
                n_count = (r_count > sz) ? r_count - sz : '0;
                n_stat  = STAT_OK;
                n_page  = r_blk;
                n_p     = r_blk;
                n_sl    = r_l;
                n_ret   = S_DONE;
                n_state = S_RM_RD;
            end
            S_MRG_RD: begin
                n_state = (r_sl == '0) ? S_FREE_END : S_MRG_CHK;
            end
            S_MRG_CHK: begin
                if (i_node_rd) begin
                    n_state = S_FREE_END;
                end else begin
                    o_node_wr.we   = 1'b1;
                    o_node_wr.addr = node_of(bd, r_sl);
                    o_node_wr.data = 1'b1;
                    n_p     = bd;
                    n_ret   = S_MRG_NEXT;
                    n_state = S_RM_RD;
                end
            end
            S_MRG_NEXT: begin
                if (bd < r_blk) begin
                    n_blk = bd;
                end
                n_sl    = r_sl - LVL_W'(1);
                n_state = S_MRG_RD;
            end
            S_FREE_END: begin
                o_node_wr.we   = 1'b1;
                o_node_wr.addr = node_of(r_blk, r_sl);
                o_node_wr.data = 1'b0;
                n_count = (sum > (LNK_W + 1)'(PAGES)) ? LNK_W'(PAGES) : sum[LNK_W-1:0];
                n_stat  = STAT_OK;
                n_p     = r_blk;
                n_ret   = S_DONE;
                n_state = S_INS1;
            end
            S_RM_RD: begin
                // Link reads for r_p are issued in this cycle.
                n_state = head[LNK_W-1] ? r_ret : S_RM_WR;
            end
            S_RM_WR: begin
                if (head == {1'b0, r_p}) begin
                    n_head[r_sl] = i_nxt_rd;
                end
                o_prv_wr.we   = !i_nxt_rd[LNK_W-1];
                o_prv_wr.addr = i_nxt_rd[PG_W-1:0];
                o_prv_wr.data = i_prv_rd;
                o_nxt_wr.we   = !i_prv_rd[LNK_W-1];
                o_nxt_wr.addr = i_prv_rd[PG_W-1:0];
                o_nxt_wr.data = i_nxt_rd;
                n_state       = r_ret;
            end
            S_INS1: begin
                o_prv_wr.we   = !head[LNK_W-1];
                o_prv_wr.addr = head[PG_W-1:0];
                o_prv_wr.data = {1'b0, r_p};
                o_nxt_wr.we   = 1'b1;
                o_nxt_wr.addr = r_p;
                o_nxt_wr.data = head;
                n_state       = S_INS2;
            end
            S_INS2: begin
                o_prv_wr.we   = 1'b1;
                o_prv_wr.addr = r_p;
                o_prv_wr.data = NIL;
                n_head[r_sl]  = {1'b0, r_p};
                n_state       = r_ret;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_ostat = r_stat;
                    n_opage = PIDX_W'(r_page);
                    n_ofree = FREE_W'(r_count);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bpa_chk.sv -----
// ============================================================================
// bpa_chk
// Port-level checks for the buddy page allocator, bound to the top level.
// ============================================================================
`default_nettype none

module bpa_chk import bpa_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [STAT_W-1:0] i_status,
    input wire logic [PIDX_W-1:0] i_result_page,
    input wire logic [FREE_W-1:0] i_free_pages
);

    // A stalled response keeps its payload until the transfer.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
        && $stable(i_result_page) && $stable(i_free_pages))
        else $error("response changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == STAT_OK || i_status == STAT_BAD_ORDER
        || i_status == STAT_NO_BLOCK))
        else $error("undefined status code");

    // Failed requests never report a page.
    a_err_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_OK |-> i_result_page == '0)
        else $error("page reported on failed request");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_free_pages) <= PAGES)
        else $error("free page count above capacity");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_result_page(o_rsp.result_page),
    .i_free_pages (o_rsp.free_pages)
);

`default_nettype wire
